// File: src/mm64a_pkg.sv
// Shared types, constants and helper functions for the MurmurHash64A core.
package mm64a_pkg;

    localparam logic [63:0] MIX_MUL       = 64'hc6a4_a793_5bd1_e995;
    localparam int unsigned MIX_SHIFT     = 47;
    localparam logic [63:0] SEED_AT_RESET = 64'h0000_0000_ee6b_27eb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MIX,
        S_K1,
        S_K2,
        S_HM,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mul_rsp_t;

    // xor-shift fold used between multiplies and on the final hash
    function automatic logic [63:0] fold(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

    // keep the low 'count' bytes of a word
    function automatic logic [63:0] low_bytes(input logic [63:0] word,
                                              input logic [3:0]  count);
        logic [63:0] kept;
        kept = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < count)
            begin
                kept[i*8 +: 8] = word[i*8 +: 8];
            end
        end
        return kept;
    endfunction

endpackage

// File: src/mm64a_mul.sv
// Iterative 64-bit by mix-constant multiplier, low 64 bits, one 32x32 multiplier.
module mm64a_mul
    import mm64a_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;

    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] mult;

    // pick the partial product for this step
    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = MIX_MUL[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = MIX_MUL[63:32];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = MIX_MUL[31:0];
            end
        endcase
    end

    assign mult = 64'(op_x) * 64'(op_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg <= req.operand;
        end
        else if (busy_reg)
        begin
            prod_reg <= mult;
            unique case (step_reg)
                2'd0: acc_reg <= acc_reg;
                2'd1: acc_reg <= prod_reg;
                2'd2: acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
                2'd3: acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// File: src/murmur64a_hash_core.sv
// Top level of the MurmurHash64A core: sequencer, hash state and output register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid / in_stall | key_word, word_bytes, key_length, last_word
//  output   | out_valid/out_stall | hash_value
//  config   | cfg_wr_en           | cfg_wr_data (hash_seed)
//
// Every 64-bit multiply runs on one shared 32x32 multiplier: three partial
// products plus accumulate and handoff. A word takes one multiply on the
// first word of a key (length times m), three for a full word, one for a
// tail, none for an empty word, and one more on a last word.
// Reset clears the sequencer, the key flag and the output valid; the seed
// returns to its fixed default. in_stall is high while a word is in work and
// while a finished hash waits behind a held result in the output register.
module murmur64a_hash_core
    import mm64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] key_word,
    input  logic [3:0]  word_bytes,
    input  logic [15:0] key_length,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data
);

    state_t      state_reg, state_next;
    logic        inside_reg, inside_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] seed_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  bytes_reg, bytes_next;
    logic        last_reg, last_next;
    logic [63:0] hash_reg, hash_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    mm64a_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Sequencer: the multiply states wait for the multiplier, then issue the next product or move on.
    always_comb
    begin
        state_next     = state_reg;
        inside_next    = inside_reg;
        h_next         = h_reg;
        word_next      = word_reg;
        bytes_next     = bytes_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        mul_req.start   = 1'b0;
        mul_req.operand = '0;

        // drop the result once the transfer completes
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = key_word;
                    bytes_next = word_bytes;
                    last_next  = last_word;
                    if (!inside_reg)
                    begin
                        // first word: start from seed, fold in length times m
                        h_next          = seed_reg;
                        mul_req.start   = 1'b1;
                        mul_req.operand = {48'h0, key_length};
                        state_next      = S_INIT;
                    end
                    else
                    begin
                        state_next = S_MIX;
                    end
                end
            end
            S_INIT:
            begin
                if (mul_rsp.done)
                begin
                    h_next      = h_reg ^ mul_rsp.result;
                    inside_next = 1'b1;
                    state_next  = S_MIX;
                end
            end
            S_MIX:
            begin
                // byte counts of eight and above all count as a full word
                priority if (bytes_reg[3])
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = word_reg;
                    state_next      = S_K1;
                end
                else if (bytes_reg != 4'd0)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ low_bytes(word_reg, bytes_reg);
                    state_next      = S_HM;
                end
                else if (last_reg)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = fold(h_reg);
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_K1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = fold(mul_rsp.result);
                    state_next      = S_K2;
                end
            end
            S_K2:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ mul_rsp.result;
                    state_next      = S_HM;
                end
            end
            S_HM:
            begin
                if (mul_rsp.done)
                begin
                    h_next = mul_rsp.result;
                    if (last_reg)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = fold(mul_rsp.result);
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = fold(mul_rsp.result);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the finished hash until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    hash_next      = h_reg;
                    out_valid_next = 1'b1;
                    h_next         = '0;
                    inside_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            inside_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= SEED_AT_RESET;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
        hash_reg  <= hash_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

// File: src/mm64a_checker.sv
// Port-level checker for the MurmurHash64A core, with its bind.
module mm64a_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] hash_value
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_value))
        else $error("held result changed or dropped");

    // an accepted word keeps the core busy the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("core took no time for a word");

    // a new result only appears at the end of work on a word
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

    // a result never follows a transfer in the very next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_word |=> !$rose(out_valid))
        else $error("result too early after last word");

endmodule

bind murmur64a_hash_core mm64a_checker u_mm64a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
);

// File: tb/mm64a_hash_checker.sv
// Checker for the MurmurHash64A core: predicts every hash and matches it at the output.
module mm64a_hash_checker
    import mm64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] key_word,
    input  logic [3:0]  word_bytes,
    input  logic [15:0] key_length,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] hash_value,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    output int          errors,
    output int          pending
);

    logic [63:0] seed_copy;
    logic [63:0] partial_hash;
    logic        key_open;
    logic [63:0] expected_hashes[$];

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] want;
        if (!rst_n)
        begin
            seed_copy    = SEED_AT_RESET;
            partial_hash = '0;
            key_open     = 1'b0;
            expected_hashes.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // retire a finished hash before taking in new words
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $display("%0t: hash %h arrived with none expected", $time, hash_value);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        $display("%0t: hash_value expected %h, actual %h",
                                 $time, want, hash_value);
                        errors <= errors + 1;
                    end
                end
            end

            if (cfg_wr_en)
                seed_copy = cfg_wr_data;

            if (in_valid && !in_stall)
            begin
                // seed and length enter only on the first word of a key
                if (!key_open)
                begin
                    partial_hash = seed_copy ^ ({48'b0, key_length} * MIX_MUL);
                    key_open     = 1'b1;
                end
                h = partial_hash;
                if (word_bytes >= 4'd8)
                begin
                    k = key_word * MIX_MUL;
                    k = k ^ (k >> MIX_SHIFT);
                    k = k * MIX_MUL;
                    h = (h ^ k) * MIX_MUL;
                end
                else if (word_bytes != 4'd0)
                begin
                    k = key_word & ({64{1'b1}} >> (8 * (8 - word_bytes)));
                    h = (h ^ k) * MIX_MUL;
                end

                if (last_word)
                begin
                    h = h ^ (h >> MIX_SHIFT);
                    h = h * MIX_MUL;
                    h = h ^ (h >> MIX_SHIFT);
                    expected_hashes.push_back(h);
                    partial_hash = '0;
                    key_open     = 1'b0;
                end
                else
                begin
                    partial_hash = h;
                end
            end

            pending <= expected_hashes.size();
        end
    end

endmodule

// File: tb/tb.sv
// Testbench top for the MurmurHash64A core: stimulus, idling, watchdog and verdict.
module tb;
    import mm64a_pkg::*;

    // Settle time that lets a word still in work in the core finish before going on.
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_WORDS    = 610;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [63:0] key_word    = '0;
    logic [3:0]  word_bytes  = '0;
    logic [15:0] key_length  = '0;
    logic        last_word   = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [63:0] hash_value;
    logic        cfg_wr_en   = 1'b0;
    logic [63:0] cfg_wr_data = '0;

    int   errors;
    int   pending;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    logic hold_req    = 1'b0;
    int   hold_left   = 0;
    int   quiet_count = 0;
    int   words_sent  = 0;

    always #5 clk = ~clk;

    murmur64a_hash_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_word   (key_word),
        .word_bytes (word_bytes),
        .key_length (key_length),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    mm64a_hash_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_word   (key_word),
        .word_bytes (word_bytes),
        .key_length (key_length),
        .last_word  (last_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .errors     (errors),
        .pending    (pending)
    );

    // Receiver: stall at random per cycle, or hold off for a long stretch on request
    // so that the held result backs up into the input and the core stalls its sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: count cycles in which no transfer and no seed write happens.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        begin
            quiet_count <= 0;
        end
        else if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Offer one key word; idle first at the sender's rate, then hold the payload
    // until the transfer completes. Valid stays high for a back-to-back next word.
    task automatic send_word(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic [15:0] len, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_word   <= word;
        word_bytes <= nbytes;
        key_length <= len;
        last_word  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait until every predicted hash has been transferred out.
    task automatic drain_hashes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the seed only once the core is idle: drain, then let a word in work finish.
    task automatic write_seed(input logic [63:0] seed);
        drain_hashes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Send one random key: mostly well-formed runs of full words plus a tail,
    // sometimes with a length that does not match, and some broken sequences.
    task automatic send_random_key();
        int          roll;
        int          nwords;
        int          nbytes_real;
        int          nfull;
        int          tail;
        logic [15:0] len;
        logic        last;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            // noise: random byte counts (oversized included), last mark at random
            nwords = $urandom_range(1, 5);
            len    = 16'($urandom);
            for (int i = 0; i < nwords; i++)
            begin
                last = ($urandom_range(3) == 0);
                send_word({$urandom, $urandom}, 4'($urandom_range(15)), len, last);
                if (last)
                    return;
            end
            return;
        end

        nbytes_real = $urandom_range(0, 40);
        len = (roll < 22) ? 16'($urandom) : 16'(nbytes_real);
        nfull = nbytes_real / 8;
        tail  = nbytes_real % 8;
        for (int i = 0; i < nfull; i++)
        begin
            // a key of whole words may end on its last full word or on an empty word
            last = (tail == 0) && (i == nfull - 1) && ($urandom_range(1) == 1);
            send_word({$urandom, $urandom}, 4'd8, len, last);
            if (last)
                return;
        end
        send_word({$urandom, $urandom}, 4'(tail), len, 1'b1);
    endtask

    task automatic run_phase(input int sender_gap, input int receiver_stall,
                             input logic [63:0] seed, input logic squeeze);
        int start;
        write_seed(seed);
        gap_pct   = sender_gap;
        stall_pct <= receiver_stall;
        if (squeeze)
        begin
            // start a long receiver hold-off while the sender keeps offering words
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        start = words_sent;
        while (words_sent - start < PHASE_WORDS)
        begin
            // now and then pause the sender until every hash is out
            if ($urandom_range(49) == 0)
                drain_hashes();
            send_random_key();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys under the reset seed, no idling.
        send_word(64'h0, 4'd0, 16'd0, 1'b1);                      // empty key
        send_word({64{1'b1}}, 4'd8, 16'd8, 1'b1);
        send_word(64'h0, 4'd8, 16'd8, 1'b1);
        for (int nb = 1; nb < 8; nb++)                            // every tail size
            send_word({64{1'b1}}, 4'(nb), 16'(nb), 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 4'd9, 16'd8, 1'b1);    // oversized counts
        send_word(64'hfedc_ba98_7654_3210, 4'd15, 16'd8, 1'b1);
        send_word(64'h8000_0000_0000_0001, 4'd3, 16'd11, 1'b0);   // short word mid-key
        send_word(64'h5555_aaaa_5555_aaaa, 4'd8, 16'd11, 1'b1);
        send_word(64'h1111_2222_3333_4444, 4'd8, 16'hffff, 1'b1); // length mismatch
        send_word(64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 16'd16, 1'b0);   // key with no tail
        send_word(64'hf0f0_f0f0_f0f0_f0f0, 4'd8, 16'd16, 1'b0);
        send_word(64'h7fff_ffff_ffff_fffe, 4'd0, 16'd16, 1'b1);
        // seed written mid-key applies from the next key on
        send_word(64'hdead_beef_cafe_f00d, 4'd8, 16'd13, 1'b0);
        write_seed({64{1'b1}});
        send_word(64'h0bad_c0de_0bad_c0de, 4'd5, 16'd13, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 4'd8, 16'd8, 1'b1);

        // Random phases: sender idles lightly, then receiver; last runs flat out
        // apart from one long receiver hold-off.
        run_phase(7, 56, 64'h0, 1'b0);
        run_phase(56, 7, {$urandom, $urandom}, 1'b0);
        run_phase(0, 0, {$urandom, $urandom}, 1'b1);

        drain_hashes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
